// ----- hw/rtl/lossless_image_predictor_residuals_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the lossless image predictor residuals core
// Concurrent checks compiled out under synthesis.
// ---------------------------------------------------------------------------
`ifndef LOSSLESS_IMAGE_PREDICTOR_RESIDUALS_CORE_MACROS_SVH
`define LOSSLESS_IMAGE_PREDICTOR_RESIDUALS_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LIPR_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define LIPR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define LIPR_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define LIPR_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ----- hw/rtl/lipr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lipr_pkg
// Shared types and constants of the lossless image predictor residuals core.
// ---------------------------------------------------------------------------
package lipr_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int ADDR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int IMG_WIDTH_W = 13;
   localparam int CNT_W       = (ADDR_W + 1 > IMG_WIDTH_W) ? ADDR_W + 1 : IMG_WIDTH_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = IMG_WIDTH_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREDICTOR_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 1'b1;
   localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET  = 13'd4096;

   typedef enum logic [3:0] {
      MODE_NONE    = 4'd0,
      MODE_W       = 4'd1,
      MODE_N       = 4'd2,
      MODE_NW      = 4'd3,
      MODE_PLANE   = 4'd4,
      MODE_W_HALF  = 4'd5,
      MODE_N_HALF  = 4'd6,
      MODE_AVERAGE = 4'd7,
      MODE_MED     = 4'd8
   } predictor_mode_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      predictor_mode_type         mode;
      logic [IMG_WIDTH_W-1:0]     image_width;
   } csr_type;

   // one classified pixel on its way to the back end
   typedef struct packed {
      pixel_type pixel;
      pixel_type above;
      logic      first_row;
      logic      first_col;
   } entry_type;

endpackage

// ----- hw/rtl/lossless_image_predictor_residuals_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lossless_image_predictor_residuals_core
// Per-channel residuals of RGB pixels against a selectable predictor.
// Path: front stage register, then queue slot, then the registered residual.
// Throughput: 1 pixel per cycle when not stalled, set by one line store read and write per pixel.
// Reset: synchronous; clears raster position, queue and output valid, sets the
// mode to none and the width to 4096. The line store is not cleared.
// ---------------------------------------------------------------------------
module lossless_image_predictor_residuals_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_red_sample,
   input  logic [7:0]                        req_green_sample,
   input  logic [7:0]                        req_blue_sample,
   input  logic                              req_start_of_image,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_residual,
   output logic [7:0]                        rsp_green_residual,
   output logic [7:0]                        rsp_blue_residual,
   input  logic                              csr_write_enable,
   input  logic [lipr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lipr_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   lipr_pkg::csr_type   csr_ff, csr_in;
   lipr_pkg::pixel_type req_pixel, rsp_residual;
   lipr_pkg::entry_type push_entry, pop_entry;
   logic                push, pop, queue_full, not_empty;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lipr_pkg::CSR_PREDICTOR_MODE:
               csr_in.mode = lipr_pkg::predictor_mode_type'(csr_write_data[3:0]);
            lipr_pkg::CSR_IMAGE_WIDTH:
               csr_in.image_width = csr_write_data[lipr_pkg::IMG_WIDTH_W-1:0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.mode        <= lipr_pkg::MODE_NONE;
         csr_ff.image_width <= lipr_pkg::IMAGE_WIDTH_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_pixel.red   = req_red_sample;
   assign req_pixel.green = req_green_sample;
   assign req_pixel.blue  = req_blue_sample;

   lipr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_start_of_image (req_start_of_image),
      .push               (push),
      .push_entry         (push_entry),
      .queue_full         (queue_full)
   );

   lipr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   lipr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_ff),
      .not_empty    (not_empty),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_residual (rsp_residual)
   );

   assign rsp_red_residual   = rsp_residual.red;
   assign rsp_green_residual = rsp_residual.green;
   assign rsp_blue_residual  = rsp_residual.blue;

endmodule

// ----- hw/rtl/lipr_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lipr_front
// Accepts pixels, tracks raster position and reads/writes the line store.
// ---------------------------------------------------------------------------
module lipr_front (
   input  logic                clock,
   input  logic                reset,
   input  lipr_pkg::csr_type   csr,
   input  logic                req_valid,
   output logic                req_stall,
   input  lipr_pkg::pixel_type req_pixel,
   input  logic                req_start_of_image,
   output logic                push,
   output lipr_pkg::entry_type push_entry,
   input  logic                queue_full
);

   logic [lipr_pkg::ADDR_W-1:0] col_ff, col_in, col_cur;
   logic                        first_row_ff, first_row_in, first_row_cur;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        accept;
   logic [lipr_pkg::CNT_W-1:0]  eff_width, col_next;
   logic                        end_of_row;

   lipr_pkg::pixel_type row_mem [lipr_pkg::MAX_WIDTH];
   lipr_pkg::pixel_type pixel_ff, above_ff;
   logic                first_row_s1_ff, first_col_s1_ff;

   assign push      = s1_valid_ff && !queue_full;
   assign req_stall = s1_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (csr.image_width == '0) begin
         eff_width = lipr_pkg::CNT_W'(1);
      end else if (lipr_pkg::CNT_W'(csr.image_width) > lipr_pkg::CNT_W'(lipr_pkg::MAX_WIDTH)) begin
         eff_width = lipr_pkg::CNT_W'(lipr_pkg::MAX_WIDTH);
      end else begin
         eff_width = lipr_pkg::CNT_W'(csr.image_width);
      end

      // start of image restarts the raster; wrap a column past the store
      if (req_start_of_image ||
          lipr_pkg::CNT_W'(col_ff) >= lipr_pkg::CNT_W'(lipr_pkg::MAX_WIDTH)) begin
         col_cur = '0;
      end else begin
         col_cur = col_ff;
      end
      first_row_cur = req_start_of_image ? 1'b1 : first_row_ff;

      col_next   = lipr_pkg::CNT_W'(col_cur) + lipr_pkg::CNT_W'(1);
      end_of_row = col_next >= eff_width;

      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (end_of_row) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in       = col_next[lipr_pkg::ADDR_W-1:0];
            first_row_in = first_row_cur;
         end
      end

      s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // read returns the previous row before this pixel overwrites it
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff         <= row_mem[col_cur];
         row_mem[col_cur] <= req_pixel;
         pixel_ff         <= req_pixel;
         first_row_s1_ff  <= first_row_cur;
         first_col_s1_ff  <= (col_cur == '0);
      end
   end

   assign push_entry.pixel     = pixel_ff;
   assign push_entry.above     = above_ff;
   assign push_entry.first_row = first_row_s1_ff;
   assign push_entry.first_col = first_col_s1_ff;

endmodule

// ----- hw/rtl/lipr_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lipr_queue
// Short FIFO between the front and back ends.
// ---------------------------------------------------------------------------
`include "lossless_image_predictor_residuals_core_macros.svh"

module lipr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lipr_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output lipr_pkg::entry_type pop_entry
);

   lipr_pkg::entry_type         slot_ff [lipr_pkg::QUEUE_DEPTH];
   logic [lipr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [lipr_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == lipr_pkg::QCNT_W'(lipr_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   function automatic logic [lipr_pkg::QPTR_W-1:0] ptr_inc(
      input logic [lipr_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == lipr_pkg::QPTR_W'(lipr_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + lipr_pkg::QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + lipr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - lipr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LIPR_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || pop)
   `LIPR_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, not_empty)
   `LIPR_ASSERT_NEXT(a_fill_tracks, clock, reset, push && !pop,
                     count_ff == $past(count_ff) + lipr_pkg::QCNT_W'(1))

endmodule

// ----- hw/rtl/lipr_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lipr_back
// Forms W, N, NW, predicts each channel and registers the residuals.
// ---------------------------------------------------------------------------
module lipr_back (
   input  logic                clock,
   input  logic                reset,
   input  lipr_pkg::csr_type   csr,
   input  logic                not_empty,
   input  lipr_pkg::entry_type pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lipr_pkg::pixel_type rsp_residual
);

   lipr_pkg::pixel_type last_x_ff, last_n_ff;
   lipr_pkg::pixel_type w_pix, n_pix, nw_pix, resid;
   lipr_pkg::pixel_type resid_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   function automatic logic [7:0] predict(
      input lipr_pkg::predictor_mode_type mode,
      input logic [7:0] w,
      input logic [7:0] n,
      input logic [7:0] nw
   );
      logic signed [9:0] d_n, d_w, half_n, half_w;
      logic [9:0]        plane;
      logic [8:0]        sum;
      logic [7:0]        lo, hi, result;
      d_n    = $signed({2'b00, n}) - $signed({2'b00, nw});
      d_w    = $signed({2'b00, w}) - $signed({2'b00, nw});
      // bias negatives by one so the shift truncates toward zero
      half_n = (d_n + $signed({9'd0, d_n[9]})) >>> 1;
      half_w = (d_w + $signed({9'd0, d_w[9]})) >>> 1;
      plane  = {2'b00, w} + {2'b00, n} - {2'b00, nw};
      sum    = {1'b0, w} + {1'b0, n};
      lo     = (w < n) ? w : n;
      hi     = (w < n) ? n : w;
      case (mode)
         lipr_pkg::MODE_W:       result = w;
         lipr_pkg::MODE_N:       result = n;
         lipr_pkg::MODE_NW:      result = nw;
         lipr_pkg::MODE_PLANE:   result = plane[7:0];
         lipr_pkg::MODE_W_HALF:  result = w + half_n[7:0];
         lipr_pkg::MODE_N_HALF:  result = n + half_w[7:0];
         lipr_pkg::MODE_AVERAGE: result = sum[8:1];
         lipr_pkg::MODE_MED: begin
            if (nw >= hi) begin
               result = lo;
            end else if (nw <= lo) begin
               result = hi;
            end else begin
               result = plane[7:0];
            end
         end
         default:                result = 8'd0;
      endcase
      return result;
   endfunction

   assign pop = not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      w_pix  = pop_entry.first_col ? '0 : last_x_ff;
      nw_pix = pop_entry.first_col ? '0 : last_n_ff;
      n_pix  = pop_entry.first_row ? '0 : pop_entry.above;

      resid.red   = pop_entry.pixel.red   - predict(csr.mode, w_pix.red,   n_pix.red,   nw_pix.red);
      resid.green = pop_entry.pixel.green - predict(csr.mode, w_pix.green, n_pix.green, nw_pix.green);
      resid.blue  = pop_entry.pixel.blue  - predict(csr.mode, w_pix.blue,  n_pix.blue,  nw_pix.blue);

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // neighbours advance in raster order, one per popped pixel
   always_ff @(posedge clock) begin
      if (pop) begin
         resid_ff  <= resid;
         last_x_ff <= pop_entry.pixel;
         last_n_ff <= n_pix;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_residual = resid_ff;

endmodule

// ----- test/lossless_image_predictor_residuals_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lossless_image_predictor_residuals_core_test
// Self-checking bench: drives RGB pixel streams through the core under a
// range of predictor modes and row widths, predicts each residual in a
// scoreboard that mirrors the raster state and line store, and compares
// every result transaction against the oldest pending prediction.
// ---------------------------------------------------------------------------

class residual_scoreboard;
   lipr_pkg::pixel_type              line_store [lipr_pkg::MAX_WIDTH];
   bit                               line_written [lipr_pkg::MAX_WIDTH];
   lipr_pkg::pixel_type              left_pixel;
   lipr_pkg::pixel_type              upper_left;
   int unsigned                      column;
   bit                               first_row;
   logic [3:0]                       mode;
   logic [lipr_pkg::IMG_WIDTH_W-1:0] width;
   lipr_pkg::pixel_type              pending_residuals [$];
   int unsigned                      failures;

   function new();
      left_pixel = '0;
      upper_left = '0;
      column     = 0;
      first_row  = 1'b1;
      mode       = lipr_pkg::MODE_NONE;
      width      = lipr_pkg::IMAGE_WIDTH_RESET;
      failures   = 0;
      foreach (line_written[i]) line_written[i] = 1'b0;
   endfunction

   function int pending();
      return pending_residuals.size();
   endfunction

   // a pixel here would read a line store entry that was never written
   function bit needs_restart();
      return !first_row && !line_written[column];
   endfunction

   function logic [7:0] residual(logic [7:0] x, int w, int n, int nw);
      int lo;
      int hi;
      int p;
      int d;
      lo = (w < n) ? w : n;
      hi = (w < n) ? n : w;
      case (mode)
         lipr_pkg::MODE_W:       p = w;
         lipr_pkg::MODE_N:       p = n;
         lipr_pkg::MODE_NW:      p = nw;
         lipr_pkg::MODE_PLANE:   p = w + n - nw;
         lipr_pkg::MODE_W_HALF:  p = w + (n - nw) / 2;
         lipr_pkg::MODE_N_HALF:  p = n + (w - nw) / 2;
         lipr_pkg::MODE_AVERAGE: p = (w + n) / 2;
         lipr_pkg::MODE_MED: begin
            if (nw >= hi) p = lo;
            else if (nw <= lo) p = hi;
            else p = w + n - nw;
         end
         default:                p = 0;
      endcase
      d = int'(x) - p;
      return d[7:0];
   endfunction

   function void note_pixel(lipr_pkg::pixel_type x, bit start_of_image);
      int unsigned         eff_width;
      lipr_pkg::pixel_type above;
      lipr_pkg::pixel_type res;
      eff_width = (width == 0) ? 1 :
                  (width > lipr_pkg::MAX_WIDTH) ? lipr_pkg::MAX_WIDTH : width;
      if (start_of_image) begin
         column     = 0;
         first_row  = 1'b1;
         left_pixel = '0;
         upper_left = '0;
      end
      if (column >= lipr_pkg::MAX_WIDTH) column = 0;
      if (column == 0) begin
         left_pixel = '0;
         upper_left = '0;
      end
      above     = first_row ? lipr_pkg::pixel_type'('0) : line_store[column];
      res.red   = residual(x.red, left_pixel.red, above.red, upper_left.red);
      res.green = residual(x.green, left_pixel.green, above.green, upper_left.green);
      res.blue  = residual(x.blue, left_pixel.blue, above.blue, upper_left.blue);
      pending_residuals.push_back(res);
      line_store[column]   = x;
      line_written[column] = 1'b1;
      left_pixel           = x;
      upper_left           = above;
      if (column + 1 >= eff_width) begin
         column     = 0;
         first_row  = 1'b0;
         left_pixel = '0;
         upper_left = '0;
      end else begin
         column++;
      end
   endfunction

   function void check(lipr_pkg::pixel_type got);
      lipr_pkg::pixel_type want;
      if (pending_residuals.size() == 0) begin
         $error("residual transaction with no pixel pending: %h", got);
         failures++;
         return;
      end
      want = pending_residuals.pop_front();
      if (got.red !== want.red) begin
         $error("red_residual: expected %0d, actual %0d", want.red, got.red);
         failures++;
      end
      if (got.green !== want.green) begin
         $error("green_residual: expected %0d, actual %0d", want.green, got.green);
         failures++;
      end
      if (got.blue !== want.blue) begin
         $error("blue_residual: expected %0d, actual %0d", want.blue, got.blue);
         failures++;
      end
   endfunction
endclass

module lossless_image_predictor_residuals_core_test;

   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         PHASES         = 16;
   localparam logic [3:0] MODE_UNKNOWN   = 4'hF;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_red_sample;
   logic [7:0]                       req_green_sample;
   logic [7:0]                       req_blue_sample;
   logic                             req_start_of_image;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [7:0]                       rsp_red_residual;
   logic [7:0]                       rsp_green_residual;
   logic [7:0]                       rsp_blue_residual;
   logic                             csr_write_enable;
   logic [lipr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lipr_pkg::CSR_DATA_W-1:0]  csr_write_data;

   residual_scoreboard     board;
   int                     idle_pct;
   int                     stall_pct;
   int                     idle_cycles;

   lossless_image_predictor_residuals_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red_sample     (req_red_sample),
      .req_green_sample   (req_green_sample),
      .req_blue_sample    (req_blue_sample),
      .req_start_of_image (req_start_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_residual   (rsp_red_residual),
      .rsp_green_residual (rsp_green_residual),
      .rsp_blue_residual  (rsp_blue_residual),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check('{blue: rsp_blue_residual, green: rsp_green_residual,
                          red: rsp_red_residual});
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic lipr_pkg::pixel_type make_pixel(
      logic [7:0] r, logic [7:0] g, logic [7:0] b
   );
      lipr_pkg::pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      return px;
   endfunction

   function automatic logic [7:0] random_sample();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_pixel(lipr_pkg::pixel_type px, bit start_of_image);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      // restart the image rather than read an unwritten line store entry
      start_of_image = start_of_image | board.needs_restart();
      req_valid          <= 1'b1;
      req_red_sample     <= px.red;
      req_green_sample   <= px.green;
      req_blue_sample    <= px.blue;
      req_start_of_image <= start_of_image;
      do @(posedge clock); while (req_stall);
      board.note_pixel(px, start_of_image);
   endtask

   task automatic wait_drain();
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [3:0] mode,
                            logic [lipr_pkg::IMG_WIDTH_W-1:0] row_width);
      logic [lipr_pkg::CSR_DATA_W-1:0] mode_word;
      mode_word        = lipr_pkg::CSR_DATA_W'($urandom);
      mode_word[3:0]   = mode;
      csr_write_enable <= 1'b1;
      csr_index        <= lipr_pkg::CSR_PREDICTOR_MODE;
      csr_write_data   <= mode_word;
      @(posedge clock);
      csr_index        <= lipr_pkg::CSR_IMAGE_WIDTH;
      csr_write_data   <= row_width;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.mode  = mode;
      board.width = row_width;
   endtask

   initial begin
      int                               phase;
      int                               count;
      logic [lipr_pkg::IMG_WIDTH_W-1:0] row_width;
      bit                               soi;
      board              = new();
      idle_pct           = 0;
      stall_pct          = 0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_red_sample     <= '0;
      req_green_sample   <= '0;
      req_blue_sample    <= '0;
      req_start_of_image <= 1'b0;
      rsp_stall          <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // median edge on a two-pixel row, extremes, restart in mid-row
      configure(lipr_pkg::MODE_MED, 13'd2);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255), 1'b1);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0), 1'b0);
      send_pixel(make_pixel(8'd0, 8'd255, 8'd128), 1'b0);
      send_pixel(make_pixel(8'd255, 8'd0, 8'd7), 1'b0);
      send_pixel(make_pixel(8'd128, 8'd128, 8'd128), 1'b0);
      send_pixel(make_pixel(8'd1, 8'd254, 8'd255), 1'b1);
      send_pixel(make_pixel(8'd200, 8'd10, 8'd90), 1'b0);
      send_pixel(make_pixel(8'd0, 8'd255, 8'd0), 1'b0);
      req_valid <= 1'b0;
      wait_drain();

      // unknown mode with a zero width, which acts as one pixel per row
      configure(MODE_UNKNOWN, 13'd0);
      send_pixel(make_pixel(8'd17, 8'd255, 8'd0), 1'b0);
      send_pixel(make_pixel(8'd255, 8'd0, 8'd99), 1'b0);
      send_pixel(make_pixel(8'd0, 8'd1, 8'd255), 1'b0);
      send_pixel(make_pixel(8'd64, 8'd192, 8'd32), 1'b0);
      req_valid <= 1'b0;
      wait_drain();

      // width above the line store depth clamps to the maximum
      configure(lipr_pkg::MODE_W_HALF, 13'd8191);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0), 1'b1);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255), 1'b0);
      send_pixel(make_pixel(8'd3, 8'd250, 8'd127), 1'b0);
      req_valid <= 1'b0;
      wait_drain();

      // shrink the width in mid-row: the row ends at the next pixel
      configure(lipr_pkg::MODE_PLANE, 13'd4);
      send_pixel(make_pixel(8'd10, 8'd20, 8'd30), 1'b1);
      send_pixel(make_pixel(8'd255, 8'd0, 8'd255), 1'b0);
      send_pixel(make_pixel(8'd0, 8'd255, 8'd0), 1'b0);
      send_pixel(make_pixel(8'd90, 8'd180, 8'd45), 1'b0);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd0), 1'b0);
      send_pixel(make_pixel(8'd0, 8'd0, 8'd255), 1'b0);
      req_valid <= 1'b0;
      wait_drain();
      configure(lipr_pkg::MODE_PLANE, 13'd2);
      send_pixel(make_pixel(8'd77, 8'd0, 8'd200), 1'b0);
      send_pixel(make_pixel(8'd255, 8'd128, 8'd1), 1'b0);
      send_pixel(make_pixel(8'd5, 8'd250, 8'd60), 1'b0);
      req_valid <= 1'b0;
      wait_drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         case (phase % 8)
            0: row_width = 13'd1;
            1: row_width = 13'd2;
            2: row_width = lipr_pkg::IMG_WIDTH_W'($urandom_range(3, 16));
            3: row_width = lipr_pkg::IMG_WIDTH_W'($urandom_range(17, 100));
            4: row_width = 13'd0;
            5: row_width = lipr_pkg::IMG_WIDTH_W'($urandom_range(100, 600));
            6: begin
               case ($urandom_range(2))
                  0:       row_width = lipr_pkg::IMAGE_WIDTH_RESET;
                  1:       row_width = 13'd8191;
                  default: row_width = lipr_pkg::IMG_WIDTH_W'($urandom_range(4097, 8191));
               endcase
            end
            default: row_width = lipr_pkg::IMG_WIDTH_W'($urandom_range(3, 40));
         endcase
         configure(phase[3:0], row_width);
         count = $urandom_range(80, 160);
         for (int k = 0; k < count; k++) begin
            // hold the sender until every pending residual is back
            if (phase == 5 && k == count / 2) begin
               req_valid <= 1'b0;
               wait_drain();
            end
            soi = (k == 0 && phase % 3 != 0) || ($urandom_range(49) == 0);
            send_pixel(make_pixel(random_sample(), random_sample(), random_sample()), soi);
         end
         req_valid <= 1'b0;
         wait_drain();
      end

      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
